FILE: rtl/apsel_pkg.sv
package apsel_pkg;

   localparam int POP_MAX     = 128;
   localparam int PARENTS_MAX = 64;
   localparam int IDX_W       = $clog2(POP_MAX);
   localparam int CNT_W       = IDX_W + 1;
   localparam int PAR_W       = $clog2(PARENTS_MAX);
   localparam int EXP_BITS    = 20;
   localparam int DIV_BITS    = 48;

   localparam logic [1:0] REG_NUM_PARENTS = 2'd0;
   localparam logic [1:0] REG_POP_SIZE    = 2'd1;
   localparam logic [1:0] REG_START_TEMP  = 2'd2;
   localparam logic [1:0] REG_COOLING     = 2'd3;

   localparam logic [6:0]  NUM_PARENTS_RESET = 7'd1;
   localparam logic [7:0]  POP_SIZE_RESET    = 8'd100;
   localparam logic [31:0] START_TEMP_RESET  = 32'd65536000;
   localparam logic [15:0] COOLING_RESET     = 16'd31130;

   localparam logic [31:0] EXP_TAB [EXP_BITS] = '{
      32'd4294901760, 32'd4294836225, 32'd4294705159, 32'd4294443039,
      32'd4293918847, 32'd4292870655, 32'd4290775039, 32'd4286586874,
      32'd4278222805, 32'd4261543595, 32'd4228379999, 32'd4162825044,
      32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
      32'd1580030168, 32'd581260615,  32'd78665070,   32'd1440801
   };

   typedef enum logic [3:0] {
      ST_LOAD, ST_SCAN, ST_PRD, ST_PWAIT, ST_ACC, ST_WRITE, ST_OSCAN, ST_OEMIT, ST_COOL
   } state_type;

   typedef enum logic [1:0] {
      A_IDLE, A_DIV, A_EXP, A_DONE
   } acc_state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] diff;
      logic [31:0] temp;
      logic [15:0] draw;
   } acc_req_type;

   typedef struct packed {
      logic done;
      logic take;
   } acc_rsp_type;

endpackage

FILE: rtl/apsel_if.sv
interface apsel_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] fitness;
   logic        [15:0] random_draw;
   modport source (output valid, fitness, random_draw, input ready);
   modport sink   (input valid, fitness, random_draw, output ready);
endinterface

interface apsel_rsp_if;
   logic               valid;
   logic               ready;
   logic        [5:0]  slot;
   logic        [6:0]  source_index;
   logic signed [31:0] survivor_fitness;
   logic               replaced;
   logic        [31:0] temperature_used;
   logic               last;
   modport source (output valid, slot, source_index, survivor_fitness, replaced,
                   temperature_used, last, input ready);
   modport sink   (input valid, slot, source_index, survivor_fitness, replaced,
                   temperature_used, last, output ready);
endinterface

FILE: rtl/apsel_ram.sv
module apsel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/apsel_accept.sv
module apsel_accept (
   input  logic                  clock,
   input  logic                  reset,
   input  apsel_pkg::acc_req_type req,
   output apsel_pkg::acc_rsp_type rsp
);
   apsel_pkg::acc_state_type state_ff, state_in;
   logic [apsel_pkg::DIV_BITS-1:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] t_ff, t_in;
   logic [15:0] draw_ff, draw_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [4:0]  j_ff, j_in;
   logic [31:0] r_ff, r_in;
   logic        rone_ff, rone_in;
   logic        take_ff, take_in;
   logic [32:0] rem_sh;
   logic        ge;
   logic [63:0] prod;
   logic [16:0] level;
   logic        big;

   assign rem_sh = {rem_ff, num_ff[apsel_pkg::DIV_BITS-1]};
   assign ge     = rem_sh >= {1'b0, t_ff};
   assign prod   = r_ff * apsel_pkg::EXP_TAB[j_ff];
   assign level  = rone_ff ? 17'h10000 : {1'b0, r_ff[31:16]};
   assign big    = |num_ff[apsel_pkg::DIV_BITS-1:apsel_pkg::EXP_BITS];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apsel_pkg::A_IDLE: if (req.start) state_in = apsel_pkg::A_DIV;
         apsel_pkg::A_DIV:  if (cnt_ff == 6'(apsel_pkg::DIV_BITS - 1)) state_in = apsel_pkg::A_EXP;
         apsel_pkg::A_EXP:  if (big || j_ff == 5'(apsel_pkg::EXP_BITS)) state_in = apsel_pkg::A_DONE;
         apsel_pkg::A_DONE: state_in = apsel_pkg::A_IDLE;
         default:           state_in = apsel_pkg::A_IDLE;
      endcase
   end

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      t_in    = t_ff;
      draw_in = draw_ff;
      cnt_in  = cnt_ff;
      j_in    = j_ff;
      r_in    = r_ff;
      rone_in = rone_ff;
      take_in = take_ff;
      unique case (state_ff)
         apsel_pkg::A_IDLE: begin
            num_in  = {req.diff, 16'd0};
            rem_in  = '0;
            t_in    = req.temp;
            draw_in = req.draw;
            cnt_in  = '0;
            j_in    = '0;
            rone_in = 1'b1;
         end
         apsel_pkg::A_DIV: begin
            rem_in = ge ? 32'(rem_sh - {1'b0, t_ff}) : rem_sh[31:0];
            num_in = {num_ff[apsel_pkg::DIV_BITS-2:0], ge};
            cnt_in = cnt_ff + 6'd1;
         end
         apsel_pkg::A_EXP: begin
            if (big) begin
               take_in = 1'b0;
            end else if (j_ff == 5'(apsel_pkg::EXP_BITS)) begin
               take_in = {1'b0, draw_ff} < level;
            end else begin
               if (num_ff[j_ff]) begin
                  r_in    = rone_ff ? apsel_pkg::EXP_TAB[j_ff] : prod[63:32];
                  rone_in = 1'b0;
               end
               j_in = j_ff + 5'd1;
            end
         end
         apsel_pkg::A_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apsel_pkg::A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      t_ff    <= t_in;
      draw_ff <= draw_in;
      cnt_ff  <= cnt_in;
      j_ff    <= j_in;
      r_ff    <= r_in;
      rone_ff <= rone_in;
      take_ff <= take_in;
   end

   assign rsp.done = state_ff == apsel_pkg::A_DONE;
   assign rsp.take = take_ff;
endmodule

FILE: rtl/annealing_parent_selection_top.sv
// Annealing parent selection. Fitness items load one per cycle while req is
// ready; the first P items of a generation are parents, the rest children.
// After the last item input stalls while the block ranks children and pairs
// them with parents: each rank is a scan over the children through the single
// read port of the fitness memory, followed by a state to read the parent, one
// to compare and one to write the survivor. A pairing whose child is worse
// also runs a shift-subtract divider, the exponent multiply chain and a
// handoff state. Survivors then come out in sorted order, each found by a scan
// over the survivor memory, one transfer per survivor; the temperature cools
// in the state that follows the last transfer. Configuration is to be written
// by the user only while the block is idle; the block does not enforce this.
// A write of the start temperature reloads the working temperature.
module annealing_parent_selection_top (
   input  logic        clock,
   input  logic        reset,
   apsel_req_if.sink   req_if,
   apsel_rsp_if.source rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int IW = apsel_pkg::IDX_W;
   localparam int CW = apsel_pkg::CNT_W;
   localparam int PW = apsel_pkg::PAR_W;

   apsel_pkg::state_type state_ff, state_in;

   // configuration
   logic [6:0]  np_reg_ff;
   logic [7:0]  pop_reg_ff;
   logic [15:0] cf_ff;
   logic [31:0] temp_ff, temp_in;

   // sequencing
   logic [CW-1:0] lc_ff, lc_in;
   logic [CW-1:0] ccnt_ff, ccnt_in;
   logic          pv_ff, pv_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic          found_ff, found_in;
   logic [31:0]   best_f_ff, best_f_in;
   logic [IW-1:0] best_i_ff, best_i_in;
   logic [PW-1:0] best_k_ff, best_k_in;
   logic [apsel_pkg::POP_MAX-1:0]     ctaken_ff, ctaken_in;
   logic [apsel_pkg::PARENTS_MAX-1:0] otaken_ff, otaken_in;
   logic [IW-1:0] pi_ff, pi_in;
   logic [31:0]   fp_ff, fp_in;
   logic          take_ff, take_in;
   logic [IW-1:0] slot_ff, slot_in;

   logic [CW-1:0] pop_eff;
   logic [IW-1:0] np_eff;
   logic [IW-1:0] np_half;

   logic          f_we;
   logic [IW-1:0] f_raddr;
   logic [31:0]   f_rdata;
   logic          d_we;
   logic [15:0]   d_rdata;
   logic          s_we;
   logic [IW+31:0] s_wdata, s_rdata;

   apsel_pkg::acc_req_type acc_req;
   apsel_pkg::acc_rsp_type acc_rsp;

   logic          req_xfer, rsp_xfer;
   logic [CW-1:0] lc_next;
   logic          scan_done, oscan_done;
   logic [47:0]   cool_prod;
   logic [32:0]   cool_sh;

   // clamp population to [2, POP_MAX], parents to [1, min(PARENTS_MAX, pop/2)]
   always_comb begin
      if (pop_reg_ff < 8'd2) begin
         pop_eff = CW'(2);
      end else if ({1'b0, pop_reg_ff} > 9'(apsel_pkg::POP_MAX)) begin
         pop_eff = CW'(apsel_pkg::POP_MAX);
      end else begin
         pop_eff = CW'(pop_reg_ff);
      end
      np_half = pop_eff[CW-1:1];
      np_eff  = IW'(np_reg_ff);
      if (np_eff > IW'(apsel_pkg::PARENTS_MAX)) np_eff = IW'(apsel_pkg::PARENTS_MAX);
      if (np_eff > np_half) np_eff = np_half;
      if (np_eff == '0) np_eff = IW'(1);
   end

   assign req_xfer   = req_if.valid && req_if.ready;
   assign rsp_xfer   = rsp_if.valid && rsp_if.ready;
   assign lc_next    = lc_ff + CW'(1);
   assign scan_done  = (ccnt_ff >= pop_eff) && !pv_ff;
   assign oscan_done = (ccnt_ff >= CW'(np_eff)) && !pv_ff;
   assign cool_prod  = temp_ff * cf_ff;
   assign cool_sh    = cool_prod[47:15];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apsel_pkg::ST_LOAD:  if (req_xfer && lc_next >= pop_eff) state_in = apsel_pkg::ST_SCAN;
         apsel_pkg::ST_SCAN:  if (scan_done) state_in = apsel_pkg::ST_PRD;
         apsel_pkg::ST_PRD:   state_in = apsel_pkg::ST_PWAIT;
         apsel_pkg::ST_PWAIT: begin
            if ($signed(best_f_ff) <= $signed(f_rdata)) state_in = apsel_pkg::ST_WRITE;
            else state_in = apsel_pkg::ST_ACC;
         end
         apsel_pkg::ST_ACC:   if (acc_rsp.done) state_in = apsel_pkg::ST_WRITE;
         apsel_pkg::ST_WRITE: begin
            if (pi_ff + IW'(1) == np_eff) state_in = apsel_pkg::ST_OSCAN;
            else state_in = apsel_pkg::ST_SCAN;
         end
         apsel_pkg::ST_OSCAN: if (oscan_done) state_in = apsel_pkg::ST_OEMIT;
         apsel_pkg::ST_OEMIT: begin
            if (rsp_xfer) begin
               if (slot_ff + IW'(1) == np_eff) state_in = apsel_pkg::ST_COOL;
               else state_in = apsel_pkg::ST_OSCAN;
            end
         end
         apsel_pkg::ST_COOL:  state_in = apsel_pkg::ST_LOAD;
         default:             state_in = apsel_pkg::ST_LOAD;
      endcase
   end

   // memory controls and handshake outputs
   always_comb begin
      f_we    = 1'b0;
      d_we    = 1'b0;
      s_we    = 1'b0;
      f_raddr = ccnt_ff[IW-1:0];
      acc_req.start = 1'b0;
      unique case (state_ff)
         apsel_pkg::ST_LOAD: begin
            f_we = req_xfer;
            d_we = req_xfer && (lc_ff < CW'(apsel_pkg::PARENTS_MAX));
         end
         apsel_pkg::ST_PRD:   f_raddr = pi_ff;
         apsel_pkg::ST_PWAIT: acc_req.start = $signed(best_f_ff) > $signed(f_rdata);
         apsel_pkg::ST_WRITE: s_we = 1'b1;
         default: begin
         end
      endcase
   end

   assign acc_req.diff = 32'(best_f_ff - f_rdata);
   assign acc_req.temp = temp_ff;
   assign acc_req.draw = d_rdata;
   assign s_wdata = take_ff ? {best_i_ff, best_f_ff} : {pi_ff, fp_ff};

   assign req_if.ready = state_ff == apsel_pkg::ST_LOAD;
   assign rsp_if.valid = state_ff == apsel_pkg::ST_OEMIT;
   assign rsp_if.slot  = slot_ff[PW-1:0];
   assign rsp_if.source_index     = best_i_ff;
   assign rsp_if.survivor_fitness = best_f_ff;
   assign rsp_if.replaced         = best_i_ff >= np_eff;
   assign rsp_if.temperature_used = temp_ff;
   assign rsp_if.last             = slot_ff + IW'(1) == np_eff;

   // datapath
   always_comb begin
      lc_in     = lc_ff;
      ccnt_in   = ccnt_ff;
      pv_in     = 1'b0;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      best_f_in = best_f_ff;
      best_i_in = best_i_ff;
      best_k_in = best_k_ff;
      ctaken_in = ctaken_ff;
      otaken_in = otaken_ff;
      pi_in     = pi_ff;
      fp_in     = fp_ff;
      take_in   = take_ff;
      slot_in   = slot_ff;
      temp_in   = temp_ff;
      unique case (state_ff)
         apsel_pkg::ST_LOAD: begin
            if (req_xfer) begin
               lc_in = lc_next;
               if (lc_next >= pop_eff) begin
                  // close the generation, start ranking the children
                  lc_in     = '0;
                  ccnt_in   = CW'(np_eff);
                  found_in  = 1'b0;
                  ctaken_in = '0;
                  pi_in     = '0;
               end
            end
         end
         apsel_pkg::ST_SCAN: begin
            // issue one child read a cycle, compare the one read last cycle
            if (ccnt_ff < pop_eff) begin
               pv_in   = !ctaken_ff[ccnt_ff[IW-1:0]];
               pidx_in = ccnt_ff[IW-1:0];
               ccnt_in = ccnt_ff + CW'(1);
            end
            if (pv_ff && (!found_ff || $signed(f_rdata) < $signed(best_f_ff))) begin
               found_in  = 1'b1;
               best_f_in = f_rdata;
               best_i_in = pidx_ff;
            end
            if (scan_done) ctaken_in[best_i_ff] = 1'b1;
         end
         apsel_pkg::ST_PWAIT: begin
            fp_in   = f_rdata;
            take_in = 1'b1;
         end
         apsel_pkg::ST_ACC: begin
            if (acc_rsp.done) take_in = acc_rsp.take;
         end
         apsel_pkg::ST_WRITE: begin
            pi_in    = pi_ff + IW'(1);
            found_in = 1'b0;
            if (pi_ff + IW'(1) == np_eff) begin
               ccnt_in   = '0;
               otaken_in = '0;
               slot_in   = '0;
            end else begin
               ccnt_in = CW'(np_eff);
            end
         end
         apsel_pkg::ST_OSCAN: begin
            if (ccnt_ff < CW'(np_eff)) begin
               pv_in   = !otaken_ff[ccnt_ff[PW-1:0]];
               pidx_in = ccnt_ff[IW-1:0];
               ccnt_in = ccnt_ff + CW'(1);
            end
            // lower fitness first, ties to the lower load index
            if (pv_ff && (!found_ff
                  || $signed(s_rdata[31:0]) < $signed(best_f_ff)
                  || (s_rdata[31:0] == best_f_ff && s_rdata[IW+31:32] < best_i_ff))) begin
               found_in  = 1'b1;
               best_f_in = s_rdata[31:0];
               best_i_in = s_rdata[IW+31:32];
               best_k_in = pidx_ff[PW-1:0];
            end
         end
         apsel_pkg::ST_OEMIT: begin
            if (rsp_xfer) begin
               otaken_in[best_k_ff] = 1'b1;
               slot_in  = slot_ff + IW'(1);
               ccnt_in  = '0;
               found_in = 1'b0;
            end
         end
         apsel_pkg::ST_COOL: begin
            if (cool_sh[32]) temp_in = 32'hFFFF_FFFF;
            else if (cool_sh[31:0] == '0) temp_in = 32'd1;
            else temp_in = cool_sh[31:0];
         end
         default: begin
         end
      endcase
      if (csr_we && csr_index == apsel_pkg::REG_START_TEMP) begin
         temp_in = (csr_data == '0) ? 32'd1 : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= apsel_pkg::ST_LOAD;
         lc_ff      <= '0;
         pv_ff      <= 1'b0;
         temp_ff    <= apsel_pkg::START_TEMP_RESET;
         np_reg_ff  <= apsel_pkg::NUM_PARENTS_RESET;
         pop_reg_ff <= apsel_pkg::POP_SIZE_RESET;
         cf_ff      <= apsel_pkg::COOLING_RESET;
      end else begin
         state_ff <= state_in;
         lc_ff    <= lc_in;
         pv_ff    <= pv_in;
         temp_ff  <= temp_in;
         if (csr_we) begin
            unique case (csr_index)
               apsel_pkg::REG_NUM_PARENTS: np_reg_ff  <= csr_data[6:0];
               apsel_pkg::REG_POP_SIZE:    pop_reg_ff <= csr_data[7:0];
               apsel_pkg::REG_START_TEMP:  begin
               end
               apsel_pkg::REG_COOLING:     cf_ff      <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
      ccnt_ff   <= ccnt_in;
      pidx_ff   <= pidx_in;
      found_ff  <= found_in;
      best_f_ff <= best_f_in;
      best_i_ff <= best_i_in;
      best_k_ff <= best_k_in;
      ctaken_ff <= ctaken_in;
      otaken_ff <= otaken_in;
      pi_ff     <= pi_in;
      fp_ff     <= fp_in;
      take_ff   <= take_in;
      slot_ff   <= slot_in;
   end

   // fitness of every individual, by load index
   apsel_ram #(.WIDTH(32), .DEPTH(apsel_pkg::POP_MAX)) u_fitness_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (lc_ff[IW-1:0]),
      .wdata (req_if.fitness),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   // parent draws
   apsel_ram #(.WIDTH(16), .DEPTH(apsel_pkg::PARENTS_MAX)) u_draw_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (lc_ff[PW-1:0]),
      .wdata (req_if.random_draw),
      .raddr (pi_ff[PW-1:0]),
      .rdata (d_rdata)
   );

   // survivors: load index and fitness, by parent position
   apsel_ram #(.WIDTH(IW + 32), .DEPTH(apsel_pkg::PARENTS_MAX)) u_surv_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (pi_ff[PW-1:0]),
      .wdata (s_wdata),
      .raddr (ccnt_ff[PW-1:0]),
      .rdata (s_rdata)
   );

   apsel_accept u_accept (
      .clock (clock),
      .reset (reset),
      .req   (acc_req),
      .rsp   (acc_rsp)
   );
endmodule

FILE: rtl/apsel_checker.sv
module apsel_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_last,
   input logic [31:0] rsp_temp
);
   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no input while survivors are out
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open during emission");

   // a non-final survivor is followed by more of the same generation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("generation closed early");

   // temperature never hits zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp != 32'd0)
      else $error("zero temperature");
endmodule

bind annealing_parent_selection_top apsel_checker u_apsel_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_last  (rsp_if.last),
   .rsp_temp  (rsp_if.temperature_used)
);
